// ===== hdl/binary_thinning_subpass_defines.svh =====
// assertion macros for the thinning sub-pass block
`ifndef BINARY_THINNING_SUBPASS_DEFINES_SVH
`define BINARY_THINNING_SUBPASS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/bts_pkg.sv =====
// shared constants for the thinning sub-pass block
package bts_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int IMG_W_W       = 11;
  localparam int ROW_W         = 12;
  localparam int OUT_COL_W     = 10;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;
  localparam int MIN_SIZE      = 3;
  localparam int B_MIN         = 2;
  localparam int B_MAX         = 6;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBPASS_SELECT = 2'd2;

  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [ROW_W-1:0]   RST_IMAGE_HEIGHT = 12'd3;

endpackage

// ===== hdl/bts_pix_if.sv =====
// pixel input channel
interface bts_pix_if;
  logic valid;
  logic ready;
  logic pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== hdl/bts_res_if.sv =====
// result channel: pixel value with its coordinates
interface bts_res_if import bts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 pixel_out;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 run_last;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input run_last, output ready);
endinterface

// ===== hdl/bts_ram.sv =====
// generic single-port-write ram with registered read
module bts_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/binary_thinning_subpass.sv =====
// one zhang-suen thinning sub-pass over a raster-order binary frame
// pixels: one binary pixel per transfer, raster order, frame size from
//   image_width / image_height; subpass_select picks the deletion products
// results: pixel value with row and column; run_last marks the final result
//   caused by one input pixel
// cfg: write cfg_en with cfg_index / cfg_data while the block is idle
// results caused by a pixel are pushed into the result queue when it is transferred
// throughput: one pixel per cycle on interior columns while results drain; a last-column
//   pixel outside the first and last rows gives two results and a last-row pixel up to
//   three, and the four-entry result queue drains one per cycle while the receiver is
//   ready, so input ready drops while more than one result is queued
// the line store is one ram with a registered read port; after a size write
//   that moves the next column, no pixel is taken until the registered read catches up
// reset clears counters, window, queue pointers and config registers to their defaults;
//   the line store holds no valid data until a row has passed
// a stalled receiver fills the queue, then holds input ready low
`include "binary_thinning_subpass_defines.svh"

module binary_thinning_subpass import bts_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  bts_pix_if.sink               pixels,
  bts_res_if.source             results,
  input  logic                  cfg_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = CW + 1;
  localparam int CMPW       = (WW > IMG_W_W) ? WW : IMG_W_W;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  localparam logic [CMPW-1:0]  MAXW_C = CMPW'(MAX_WIDTH);
  localparam logic [CMPW-1:0]  MINW_C = CMPW'(MIN_SIZE);
  localparam logic [ROW_W-1:0] MINH_C = ROW_W'(MIN_SIZE);

  typedef struct packed {
    logic                 pix;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } res_t;

  // window bit 3k+j: column k (0 left), row j (0 top)
  function automatic logic thin_pixel(input logic [8:0] win, input logic sel);
    logic [7:0] ring;
    logic [3:0] b;
    logic [3:0] a;
    logic       m1;
    logic       m2;
    ring = {win[0], win[1], win[2], win[5], win[8], win[7], win[6], win[3]};
    b = '0;
    a = '0;
    for (int k = 0; k < 8; k++) begin
      b = b + 4'(ring[k]);
      a = a + 4'(!ring[k] && ring[(k == 7) ? 0 : k + 1]);
    end
    if (sel) begin
      m1 = ring[0] & ring[2] & ring[6];
      m2 = ring[0] & ring[4] & ring[6];
    end else begin
      m1 = ring[0] & ring[2] & ring[4];
      m2 = ring[2] & ring[4] & ring[6];
    end
    if (a == 4'd1 && b >= 4'(B_MIN) && b <= 4'(B_MAX) && !m1 && !m2) begin
      return 1'b0;
    end
    return win[4];
  endfunction

  logic [IMG_W_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  logic               subpass_select;

  logic [CW-1:0]      col_count;
  logic [ROW_W-1:0]   row_count;
  logic [8:0]         window;
  logic [CW-1:0]      rd_addr_q;
  logic               rd_vld;

  res_t               q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wp;
  logic [PTR_W-1:0]   rp;
  logic [CNT_W-1:0]   cnt;

  logic [CMPW-1:0]    iw_ext;
  logic [CMPW-1:0]    w_clamp;
  logic [WW-1:0]      w_eff;
  logic [CW-1:0]      w_last;
  logic [ROW_W-1:0]   h_eff;
  logic [ROW_W-1:0]   h_last;
  logic               col_wrap;
  logic [ROW_W:0]     row_inc;
  logic [CW-1:0]      eff_c;
  logic [ROW_W-1:0]   eff_r;
  logic               c_end;
  logic               frame_end;
  logic [CW-1:0]      col_next;
  logic [ROW_W-1:0]   row_next;
  logic               accept;
  logic               pop;
  logic               rd_ok;
  logic [CW-1:0]      rd_addr;
  logic [1:0]         rd_data;
  logic               up1;
  logic               up2;
  logic [8:0]         window_next;
  logic               e0, e1, e2;
  logic [PTR_W-1:0]   pos1;
  logic [PTR_W-1:0]   pos2;
  logic [1:0]         n_push;
  res_t               cand0, cand1, cand2;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      subpass_select <= 1'b0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[ROW_W-1:0];
        REG_SUBPASS_SELECT: subpass_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturated frame size
  assign iw_ext  = CMPW'(image_width);
  assign w_clamp = (iw_ext < MINW_C) ? MINW_C : ((iw_ext > MAXW_C) ? MAXW_C : iw_ext);
  assign w_eff   = w_clamp[WW-1:0];
  assign w_last  = CW'(w_eff - WW'(1));
  assign h_eff   = (image_height < MINH_C) ? MINH_C : image_height;
  assign h_last  = h_eff - ROW_W'(1);

  // position of the next pixel, wrapped if a size write left it past the end
  assign col_wrap = {1'b0, col_count} >= w_eff;
  assign row_inc  = col_wrap ? {1'b0, row_count} + (ROW_W+1)'(1) : {1'b0, row_count};
  assign eff_r    = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
  assign eff_c    = col_wrap ? '0 : col_count;

  assign c_end     = eff_c == w_last;
  assign frame_end = c_end && (eff_r == h_last);
  assign col_next  = c_end ? '0 : eff_c + CW'(1);
  assign row_next  = c_end ? ((eff_r == h_last) ? '0 : eff_r + ROW_W'(1)) : eff_r;

  // handshakes
  assign rd_ok         = rd_vld && (rd_addr_q == eff_c);
  assign pixels.ready  = (cnt <= CNT_W'(1)) && rd_ok;
  assign accept        = pixels.valid && pixels.ready;
  assign pop           = results.valid && results.ready;

  // line store: bit 1 one row up, bit 0 two rows up
  assign rd_addr = accept ? col_next : eff_c;

  bts_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (accept),
    .waddr (eff_c),
    .wdata ({pixels.pixel_in, up1}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign up1         = rd_data[1];
  assign up2         = rd_data[0];
  assign window_next = {pixels.pixel_in, up1, up2, window[8:3]};

  // results caused by this pixel, in output order
  assign e0 = (eff_r != '0) && (eff_c != '0);
  assign e1 = (eff_r != '0) && c_end;
  assign e2 = eff_r == h_last;

  always_comb begin
    cand0.pix  = (eff_r >= ROW_W'(2) && eff_c >= CW'(2)) ?
                 thin_pixel(window_next, subpass_select) : window_next[4];
    cand0.row  = eff_r - ROW_W'(1);
    cand0.col  = OUT_COL_W'(eff_c - CW'(1));
    cand0.last = !e1 && !e2;
    cand1.pix  = up1;
    cand1.row  = eff_r - ROW_W'(1);
    cand1.col  = OUT_COL_W'(eff_c);
    cand1.last = !e2;
    cand2.pix  = pixels.pixel_in;
    cand2.row  = eff_r;
    cand2.col  = OUT_COL_W'(eff_c);
    cand2.last = 1'b1;
  end

  assign pos1   = PTR_W'(e0);
  assign pos2   = PTR_W'(e0) + PTR_W'(e1);
  assign n_push = 2'(e0) + 2'(e1) + 2'(e2);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      window    <= '0;
      rd_addr_q <= '0;
      rd_vld    <= 1'b0;
      wp        <= '0;
      rp        <= '0;
      cnt       <= '0;
    end else begin
      rd_addr_q <= rd_addr;
      rd_vld    <= 1'b1;
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
        window    <= window_next;
        wp        <= wp + PTR_W'(n_push);
      end
      if (pop) begin
        rp <= rp + PTR_W'(1);
      end
      cnt <= cnt + (accept ? CNT_W'(n_push) : '0) - CNT_W'(pop);
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (e0) begin
        q[wp] <= cand0;
      end
      if (e1) begin
        q[wp + pos1] <= cand1;
      end
      if (e2) begin
        q[wp + pos2] <= cand2;
      end
    end
  end

  assign results.valid     = cnt != '0;
  assign results.pixel_out = q[rp].pix;
  assign results.out_row   = q[rp].row;
  assign results.out_col   = q[rp].col;
  assign results.run_last  = q[rp].last;

  `BTS_ASSERT_NOW(a_queue_bound, clk, rst, 1'b1, cnt <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `BTS_ASSERT_NEXT(a_frame_wrap, clk, rst, accept && frame_end, (row_count == '0) && (col_count == '0), "counters did not wrap at frame end")
  `BTS_ASSERT_NEXT(a_push_valid, clk, rst, accept && (n_push != 2'd0), results.valid, "queued result not offered")

endmodule

// ===== tb/sv/binary_thinning_subpass_tb.sv =====
// testbench for the zhang-suen thinning sub-pass block
`timescale 1ns / 1ps

module binary_thinning_subpass_tb;
  import bts_pkg::*;

  typedef struct packed {
    logic                 pixel;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } thin_px_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bts_pix_if pix_ch ();
  bts_res_if res_ch ();

  binary_thinning_subpass uut (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pix_ch),
    .results   (res_ch),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic               prev1_line [DEF_MAX_WIDTH];
  logic               prev2_line [DEF_MAX_WIDTH];
  logic [8:0]         win3x3;
  int                 row_next;
  int                 col_next;
  logic [IMG_W_W-1:0] width_reg;
  logic [ROW_W-1:0]   height_reg;
  logic               subpass_reg;

  thin_px_t expected_px[$];
  logic     thinned_img [4096];
  logic     shape_px [4096];
  int       fail_count;
  int       items_sent;
  bit       idle_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int frame_width();
    if (width_reg < MIN_SIZE) return MIN_SIZE;
    if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(width_reg);
  endfunction

  // window bit 3*col+row, row 0 on top; ring runs p2, p3, ... p9
  function automatic logic thin_centre(logic [8:0] w, logic subpass);
    logic [7:0] ring;
    int         a;
    int         b;
    int         k;
    logic       m1;
    logic       m2;
    ring = {w[0], w[1], w[2], w[5], w[8], w[7], w[6], w[3]};
    a = 0;
    b = 0;
    for (k = 0; k < 8; k++) begin
      b += ring[k];
      if (!ring[k] && ring[(k + 1) % 8]) a++;
    end
    if (!subpass) begin
      m1 = ring[0] & ring[2] & ring[4];
      m2 = ring[2] & ring[4] & ring[6];
    end else begin
      m1 = ring[0] & ring[2] & ring[6];
      m2 = ring[0] & ring[4] & ring[6];
    end
    if (a == 1 && b >= B_MIN && b <= B_MAX && !m1 && !m2) return 1'b0;
    return w[4];
  endfunction

  function automatic void note_result(logic pix, int row, int col, logic last);
    thin_px_t px;
    int       idx;
    px.pixel = pix;
    px.row   = ROW_W'(row);
    px.col   = OUT_COL_W'(col);
    px.last  = last;
    expected_px.push_back(px);
    idx = row * frame_width() + col;
    if (idx < 4096) thinned_img[idx] = pix;
  endfunction

  function automatic void predict_thinning(logic pix);
    int   w;
    int   h;
    int   r;
    int   c;
    logic up1;
    logic up2;
    logic has_inner;
    logic has_col_end;
    logic has_last_row;
    w = frame_width();
    h = (height_reg < MIN_SIZE) ? MIN_SIZE : int'(height_reg);
    // counters may lie past a size that was shrunk mid-frame
    if (col_next >= w) begin
      col_next = 0;
      row_next++;
    end
    if (row_next >= h) row_next = 0;
    r = row_next;
    c = col_next;
    up1 = prev1_line[c];
    up2 = prev2_line[c];
    win3x3 = {pix, up1, up2, win3x3[8:3]};
    prev2_line[c] = up1;
    prev1_line[c] = pix;
    has_inner    = (r >= 1) && (c >= 1);
    has_col_end  = (r >= 1) && (c == w - 1);
    has_last_row = (r == h - 1);
    if (has_inner)
      note_result((r >= 2 && c >= 2) ? thin_centre(win3x3, subpass_reg) : win3x3[4],
                  r - 1, c - 1, !has_col_end && !has_last_row);
    if (has_col_end) note_result(up1, r - 1, c, !has_last_row);
    if (has_last_row) note_result(pix, r, c, 1'b1);
    col_next = c + 1;
    if (col_next >= w) begin
      col_next = 0;
      row_next = r + 1;
      if (row_next >= h) row_next = 0;
    end
  endfunction

  task automatic send_pixel(input logic pix);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_in <= pix;
    do @(posedge clk); while (!pix_ch.ready);
    predict_thinning(pix);
    items_sent++;
  endtask

  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(input int w_raw, input int h_raw, input int subpass);
    wait_idle();
    cfg_en    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= CFG_DATA_W'(w_raw);
    @(posedge clk);
    width_reg = IMG_W_W'(w_raw);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= CFG_DATA_W'(h_raw);
    @(posedge clk);
    height_reg = ROW_W'(h_raw);
    cfg_index <= REG_SUBPASS_SELECT;
    cfg_data  <= CFG_DATA_W'(subpass);
    @(posedge clk);
    subpass_reg = subpass[0];
    cfg_en <= 1'b0;
  endtask

  // single register write once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    wait_idle();
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:    width_reg = IMG_W_W'(value);
      REG_IMAGE_HEIGHT:   height_reg = ROW_W'(value);
      REG_SUBPASS_SELECT: subpass_reg = value[0];
      default: ;
    endcase
  endtask

  // runs on until the counters come back to the frame start
  task automatic send_random_frame(input int density);
    do send_pixel($urandom_range(0, 99) < density);
    while (row_next != 0 || col_next != 0);
  endtask

  task automatic send_pattern(input logic [8:0] bits);
    for (int i = 8; i >= 0; i--) send_pixel(bits[i]);
  endtask

  task automatic test_reset_defaults();
    idle_on = 1'b0;
    // part of a full-width first row, then a narrow width ends the row
    repeat (40) send_pixel(1'($urandom_range(0, 1)));
    write_reg(REG_IMAGE_WIDTH, 5);
    send_random_frame(50);
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    // full block: eight neighbours, kept
    set_frame(3, 3, 0);
    send_pattern(9'b111_111_111);
    // six neighbours, one transition: kept by the first products, cleared by the second
    set_frame(3, 3, 1);
    send_pattern(9'b100_111_111);
    // two neighbours, one transition: cleared
    set_frame(3, 3, 0);
    send_pattern(9'b000_011_001);
  endtask

  task automatic test_size_saturation();
    idle_on = 1'b1;
    set_frame(0, 0, 1);
    send_random_frame(50);
    set_frame(2, 1, 0);
    send_random_frame(70);
    set_frame(1, 2, 1);
    send_random_frame(30);
  endtask

  task automatic test_mid_frame_resize();
    idle_on = 1'b1;
    // narrower frame while mid-row: column wraps with a row advance
    set_frame(8, 6, 0);
    repeat (14) send_pixel(1'($urandom_range(0, 1)));
    set_frame(5, 4, 1);
    send_random_frame(60);
    // shorter frame while past its last row: row wraps to zero
    set_frame(6, 8, 0);
    repeat (32) send_pixel(1'($urandom_range(0, 1)));
    set_frame(6, 4, 1);
    send_random_frame(50);
  endtask

  task automatic test_chained_shapes();
    int start;
    int w;
    int h;
    int r0;
    int r1;
    int c0;
    int c1;
    start = items_sent;
    while (items_sent - start < 60) begin
      w = $urandom_range(4, 6);
      h = $urandom_range(4, 5);
      for (int i = 0; i < w * h; i++) shape_px[i] = 1'b0;
      repeat (2) begin
        r0 = $urandom_range(0, h - 1);
        r1 = $urandom_range(r0, h - 1);
        c0 = $urandom_range(0, w - 1);
        c1 = $urandom_range(c0, w - 1);
        for (int r = r0; r <= r1; r++)
          for (int c = c0; c <= c1; c++) shape_px[r * w + c] = 1'b1;
      end
      for (int i = 0; i < w * h; i++)
        if ($urandom_range(0, 11) == 0) shape_px[i] = ~shape_px[i];
      // sub-passes chained 0,1,0,1, each fed with the previous output
      for (int p = 0; p < 4; p++) begin
        idle_on = ($urandom_range(0, 3) != 0);
        set_frame(w, h, p % 2);
        for (int i = 0; i < w * h; i++) send_pixel(shape_px[i]);
        for (int i = 0; i < w * h; i++) shape_px[i] = thinned_img[i];
      end
      idle_on = 1'b1;
      set_frame($urandom_range(3, 12), $urandom_range(3, 8), $urandom_range(0, 1));
      send_random_frame($urandom_range(10, 90));
    end
  endtask

  task automatic test_large_frames();
    idle_on = 1'b0;
    // width saturates to the longest line, then is cut back before the row ends
    set_frame(2047, 3, 1);
    repeat (30) send_pixel(1'($urandom_range(0, 1)));
    write_reg(REG_IMAGE_WIDTH, 4);
    send_random_frame(50);
    // tallest frame, cut short after a few rows
    set_frame(3, 4095, 0);
    repeat (18) send_pixel(1'($urandom_range(0, 1)));
    write_reg(REG_IMAGE_HEIGHT, 7);
    send_random_frame(40);
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    thin_px_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_px.size() == 0) begin
        $error("unexpected result at row %0d col %0d", res_ch.out_row, res_ch.out_col);
        fail_count++;
      end else begin
        want = expected_px.pop_front();
        if (res_ch.pixel_out !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, res_ch.pixel_out);
          fail_count++;
        end
        if (res_ch.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, res_ch.out_row);
          fail_count++;
        end
        if (res_ch.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, res_ch.out_col);
          fail_count++;
        end
        if (res_ch.run_last !== want.last) begin
          $error("run_last: expected %0d, got %0d", want.last, res_ch.run_last);
          fail_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst             <= 1'b1;
    cfg_en          <= 1'b0;
    cfg_index       <= REG_IMAGE_WIDTH;
    cfg_data        <= '0;
    pix_ch.valid    <= 1'b0;
    pix_ch.pixel_in <= 1'b0;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      prev1_line[i] = 1'b0;
      prev2_line[i] = 1'b0;
    end
    win3x3      = '0;
    row_next    = 0;
    col_next    = 0;
    width_reg   = RST_IMAGE_WIDTH;
    height_reg  = RST_IMAGE_HEIGHT;
    subpass_reg = 1'b0;
    fail_count  = 0;
    items_sent  = 0;
    idle_on     = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_size_saturation();
    test_mid_frame_resize();
    test_chained_shapes();
    test_large_frames();
    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
